@@ hdl/scrc_pkg.sv @@
package scrc_pkg;

  localparam int DEF_COUNT_WIDTH = 16;
  localparam int DEF_MAX_FRAMES  = 64;
  localparam int DEF_MIN_RTT_MS  = 32;

  localparam int TIMER_INDEX_W = 5;
  localparam int FRAMES_W      = 16;
  localparam int PERIOD_W      = 24;

  // reciprocal 65536 / frames, quotient can reach 17 bits
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] RECIP_DIVIDEND = 17'h10000;

  // rtt error: dt*256 - mean needs 41 bits, one spare for the add
  localparam int ERR_W = 42;

  localparam logic [FRAMES_W-1:0] FRAMES_ONE = 16'd256;
  localparam logic [FRAMES_W-1:0] THRESH_INF = 16'hFFFF;
  localparam logic [31:0] RTT_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RTT_NEG_MAX = 32'h8000_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_SAT = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ROUND_START = 2'd0,
    KIND_ATTEMPT     = 2'd1,
    KIND_ROUND_END   = 2'd2,
    KIND_RESPONSE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RTT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] seq_number;
    logic               seq_valid;
    logic [31:0]        now_ms;
    logic [31:0]        send_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [FRAMES_W-1:0] frames_per_try;
    logic [PERIOD_W-1:0] period_ms;
    logic                response_valid;
    logic                all_found;
    logic                check_done;
    logic                congested;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic [RECIP_W-1:0] quotient;
  } recip_rsp_t;

  typedef struct packed {
    logic                due;
    logic [PERIOD_W-1:0] period_ms;
  } period_info_t;

endpackage

@@ hdl/scrc_period.sv @@
module scrc_period #(
  parameter int MIN_RTT_MS = scrc_pkg::DEF_MIN_RTT_MS
) (
  input  logic signed [31:0]                   rtt_mean_q8,
  input  logic [scrc_pkg::TIMER_INDEX_W-1:0]   timer_index,
  input  logic [31:0]                          elapsed_ms,
  output scrc_pkg::period_info_t               info
);
  import scrc_pkg::*;

  localparam int CLAMP_HI = MIN_RTT_MS * 512;
  localparam int CLAMP_W  = $clog2(CLAMP_HI + 1);
  localparam int SHIFT_W  = CLAMP_W + 31;
  localparam int FULL_W   = SHIFT_W - 8;

  localparam logic signed [31:0] LO_Q8 = 32'(MIN_RTT_MS * 256);
  localparam logic signed [31:0] HI_Q8 = 32'(CLAMP_HI);

  logic [CLAMP_W-1:0] clamped;
  logic [SHIFT_W-1:0] shifted;
  logic [FULL_W-1:0]  full;
  logic               over32;
  logic               over24;

  always_comb begin
    priority if (rtt_mean_q8 < LO_Q8) begin
      clamped = LO_Q8[CLAMP_W-1:0];
    end else if (rtt_mean_q8 > HI_Q8) begin
      clamped = HI_Q8[CLAMP_W-1:0];
    end else begin
      clamped = rtt_mean_q8[CLAMP_W-1:0];
    end
  end

  assign shifted = SHIFT_W'(clamped) << timer_index;
  assign full    = shifted[SHIFT_W-1:8];
  assign over32  = |full[FULL_W-1:32];
  assign over24  = |full[FULL_W-1:PERIOD_W];

  // a period beyond 32 bits can never have elapsed
  assign info.due       = !over32 && (elapsed_ms >= full[31:0]);
  assign info.period_ms = over24 ? PERIOD_SAT : full[PERIOD_W-1:0];

endmodule

@@ hdl/scrc_recip.sv @@
module scrc_recip (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [scrc_pkg::FRAMES_W-1:0]     divisor,
  output scrc_pkg::recip_rsp_t              rsp
);
  import scrc_pkg::*;

  localparam int CNT_W = $clog2(RECIP_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [FRAMES_W-1:0] rem_r;
  logic [RECIP_W-1:0]  dvd_r;
  logic [RECIP_W-1:0]  quo_r;
  logic [FRAMES_W-1:0] dvs_r;

  logic [FRAMES_W:0]   trial;
  logic                fits;
  logic [FRAMES_W:0]   diff;

  // one restoring step per cycle
  assign trial = {rem_r, dvd_r[RECIP_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RECIP_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      dvd_r <= RECIP_DIVIDEND;
      quo_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
      quo_r <= {quo_r[RECIP_W-2:0], fits};
      dvd_r <= {dvd_r[RECIP_W-2:0], 1'b0};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hdl/search_congestion_rate_controller_unit.sv @@
// search congestion rate controller for one search timer
// in channel: in_valid / in_stall / in_data, one event per request (round start,
//   attempt sent, round end, search response); in_stall is high while an event
//   is being worked on
// out channel: out_valid / out_stall / out_data, exactly one result per event,
//   carrying frames per try, the search period and the event flags
// cfg port: cfg_wr_en / cfg_wr_data load the timer index; write only while idle
// latency: the result register loads 2 cycles after the request is taken, 3 for
//   a counted response (rtt add), and 20 when frames grow by congestion
//   avoidance, where the shared reciprocal divider runs 17 restoring steps
// throughput: one event per 3 to 4 cycles, up to 21 cycles for a growth step;
//   the divider and the single sequencer set that figure
// a finished result sits in the output register, so the next request is taken
//   while the receiver stalls; only a second result waits on out_stall
// reset (rst_n low, synchronous): counters clear, frames 1.0, threshold infinite,
//   rtt mean at the minimum rtt, timer index 0, no result pending
module search_congestion_rate_controller_unit #(
  parameter int COUNT_WIDTH = scrc_pkg::DEF_COUNT_WIDTH,
  parameter int MAX_FRAMES  = scrc_pkg::DEF_MAX_FRAMES,
  parameter int MIN_RTT_MS  = scrc_pkg::DEF_MIN_RTT_MS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  scrc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output scrc_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [scrc_pkg::TIMER_INDEX_W-1:0]  cfg_wr_data
);
  import scrc_pkg::*;

  localparam int MW = COUNT_WIDTH + 4;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [FRAMES_W-1:0] MAX_FRAMES_Q8 = 16'(MAX_FRAMES * 256);

  state_t state_r, state_nxt;

  logic [TIMER_INDEX_W-1:0] timer_index_r;
  logic [COUNT_WIDTH-1:0]   attempt_count_r;
  logic [COUNT_WIDTH-1:0]   response_count_r;
  logic [FRAMES_W-1:0]      frames_q8_r;
  logic [FRAMES_W-1:0]      congest_threshold_q8_r;
  logic signed [31:0]       window_start_seq_r;
  logic signed [31:0]       window_end_seq_r;
  logic signed [31:0]       rtt_mean_q8_r;
  logic [31:0]              last_check_ms_r;

  in_item_t                 item_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     resp_ok_r;
  logic                     all_found_r;
  logic                     check_done_r;
  logic                     congested_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic                     accept;
  logic                     recip_start;
  logic                     out_load;
  recip_rsp_t               recip_rsp;
  period_info_t             period_info;

  logic [31:0]              elapsed_ms;
  logic [MW-1:0]            resp_x10;
  logic [MW-1:0]            att_x9;
  logic                     success;
  logic                     can_grow;
  logic                     need_div;
  logic [FRAMES_W:0]        frames_x2;
  logic [FRAMES_W-1:0]      frames_ss;
  logic                     in_window;
  logic                     resp_ok;
  logic [COUNT_WIDTH-1:0]   resp_inc;
  logic signed [31:0]       dt;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [ERR_W-1:0]  rtt_sum;
  logic [31:0]              rtt_sat;
  logic [FRAMES_W-1:0]      recip_val;

  scrc_period #(
    .MIN_RTT_MS (MIN_RTT_MS)
  ) u_period (
    .rtt_mean_q8 (rtt_mean_q8_r),
    .timer_index (timer_index_r),
    .elapsed_ms  (elapsed_ms),
    .info        (period_info)
  );

  scrc_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recip_start),
    .divisor (frames_q8_r),
    .rsp     (recip_rsp)
  );

  // round start decision
  assign elapsed_ms = item_r.now_ms - last_check_ms_r;
  assign resp_x10   = (MW'(response_count_r) << 3) + (MW'(response_count_r) << 1);
  assign att_x9     = (MW'(attempt_count_r) << 3) + MW'(attempt_count_r);
  assign success    = resp_x10 >= att_x9;
  assign can_grow   = success && (frames_q8_r < MAX_FRAMES_Q8);
  assign frames_x2  = {frames_q8_r, 1'b0};
  assign frames_ss  = (frames_x2 < {1'b0, congest_threshold_q8_r}) ?
                      frames_x2[FRAMES_W-1:0] : congest_threshold_q8_r;
  assign need_div   = (item_r.kind == KIND_ROUND_START) && period_info.due &&
                      (attempt_count_r != '0) && can_grow &&
                      (frames_q8_r >= congest_threshold_q8_r);

  // response window and rtt
  assign in_window = (window_start_seq_r <= item_r.seq_number) &&
                     (item_r.seq_number <= window_end_seq_r);
  assign resp_ok   = !item_r.seq_valid || in_window;
  assign resp_inc  = response_count_r + 1'b1;
  assign dt        = item_r.now_ms - item_r.send_time_ms;
  assign err_nxt   = {{(ERR_W - 40){dt[31]}}, dt, 8'b0} - ERR_W'(rtt_mean_q8_r);
  assign rtt_sum   = ERR_W'(rtt_mean_q8_r) + (err_r >>> 2);

  always_comb begin
    if ((&rtt_sum[ERR_W-1:31]) || !(|rtt_sum[ERR_W-1:31])) begin
      rtt_sat = rtt_sum[31:0];
    end else begin
      rtt_sat = rtt_sum[ERR_W-1] ? RTT_NEG_MAX : RTT_POS_MAX;
    end
  end

  assign recip_val = (frames_q8_r == '0) ? '0 : recip_rsp.quotient[FRAMES_W-1:0];

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (item_r.kind == KIND_RESPONSE && resp_ok) begin
          state_nxt = ST_RTT;
        end else if (need_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RTT: state_nxt = ST_FINISH;
      ST_DIV: begin
        if (recip_rsp.done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    recip_start = (state_r == ST_EVAL) && need_div;
    out_load    = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                <= ST_IDLE;
      timer_index_r          <= '0;
      attempt_count_r        <= '0;
      response_count_r       <= '0;
      frames_q8_r            <= FRAMES_ONE;
      congest_threshold_q8_r <= THRESH_INF;
      window_start_seq_r     <= '0;
      window_end_seq_r       <= '0;
      rtt_mean_q8_r          <= 32'(MIN_RTT_MS * 256);
      last_check_ms_r        <= '0;
      resp_ok_r              <= 1'b0;
      all_found_r            <= 1'b0;
      check_done_r           <= 1'b0;
      congested_r            <= 1'b0;
      out_valid_r            <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) timer_index_r <= cfg_wr_data;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            resp_ok_r    <= 1'b0;
            all_found_r  <= 1'b0;
            check_done_r <= 1'b0;
            congested_r  <= 1'b0;
          end
        end
        ST_EVAL: begin
          unique case (item_r.kind)
            KIND_ROUND_START: begin
              if (period_info.due) begin
                last_check_ms_r <= item_r.now_ms;
                check_done_r    <= 1'b1;
                if (attempt_count_r != '0) begin
                  if (!success) begin
                    congested_r            <= 1'b1;
                    congest_threshold_q8_r <= frames_q8_r >> 1;
                    frames_q8_r            <= FRAMES_ONE;
                  end else if (can_grow &&
                               (frames_q8_r < congest_threshold_q8_r)) begin
                    frames_q8_r <= frames_ss;
                  end
                end
              end
              window_start_seq_r <= item_r.seq_number;
              attempt_count_r    <= '0;
              response_count_r   <= '0;
            end
            KIND_ATTEMPT: begin
              if (attempt_count_r != COUNT_MAX) attempt_count_r <= attempt_count_r + 1'b1;
              window_end_seq_r <= item_r.seq_number + 32'sd1;
            end
            KIND_ROUND_END: begin
              window_end_seq_r <= item_r.seq_number;
            end
            KIND_RESPONSE: begin
              if (resp_ok) begin
                resp_ok_r <= 1'b1;
                err_r     <= err_nxt;
                if (response_count_r != COUNT_MAX) begin
                  response_count_r <= resp_inc;
                  all_found_r      <= (resp_inc == attempt_count_r);
                end
              end
            end
            default: ;
          endcase
        end
        ST_RTT: rtt_mean_q8_r <= rtt_sat;
        ST_DIV: begin
          // congestion avoidance: frames += 1/frames
          if (recip_rsp.done) frames_q8_r <= frames_q8_r + recip_val;
        end
        ST_FINISH: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (out_load) begin
      out_data_r.frames_per_try <= frames_q8_r;
      out_data_r.period_ms      <= period_info.period_ms;
      out_data_r.response_valid <= resp_ok_r;
      out_data_r.all_found      <= all_found_r;
      out_data_r.check_done     <= check_done_r;
      out_data_r.congested      <= congested_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_frames_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    frames_q8_r != '0)
    else $error("frames per try reached zero");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    recip_rsp.done |-> state_r == ST_DIV)
    else $error("reciprocal finished outside the divide state");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EVAL)
    else $error("accepted request not evaluated next cycle");

  a_congested_checked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.congested |-> out_data_r.check_done)
    else $error("congested result without a check");

  a_flag_groups: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.check_done && out_data_r.response_valid))
    else $error("round start and response flags in one result");

endmodule
